// ===== hw/rtl/modular_exponentiation_macros.svh =====
// Assertion macros used by the modular exponentiation top level.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define MX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MX_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define MX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/modexp_pkg.sv =====
// Shared constants for the modular exponentiation block.
package modexp_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FIELD_BITS    = 32;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [FIELD_BITS-1:0] MOD_RESET = 32'd1;
  localparam logic [FIELD_BITS-1:0] EXP_RESET = 32'd65537;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_EXPONENT = 1'b1;

endpackage

// ===== hw/rtl/modexp_mulmod.sv =====
// Interleaved shift-add modular multiplier, one multiplier bit per cycle.
module modexp_mulmod import modexp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 op_start,
  input  logic [WORD_BITS-1:0] op_a,
  input  logic [WORD_BITS-1:0] op_b,
  input  logic [WORD_BITS:0]   op_n,
  output logic                 op_done,
  output logic [WORD_BITS-1:0] op_r
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] a_r, a_nxt;
  logic [WORD_BITS-1:0] b_r, b_nxt;
  logic [WORD_BITS-1:0] r_r, r_nxt;

  logic [WORD_BITS+1:0] t;
  logic [WORD_BITS+1:0] n1;
  logic [WORD_BITS+1:0] n2;
  logic [WORD_BITS+1:0] t_red;

  // With r < n and a < n, 2r + a stays below 3n, so one of three
  // candidates is the reduced value.
  assign n1 = (WORD_BITS+2)'(op_n);
  assign n2 = {op_n, 1'b0};
  assign t  = {1'b0, r_r, 1'b0} + (b_r[WORD_BITS-1] ? (WORD_BITS+2)'(a_r) : '0);

  always_comb begin
    priority if (t >= n2) begin
      t_red = t - n2;
    end else if (t >= n1) begin
      t_red = t - n1;
    end else begin
      t_red = t;
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    if (busy_r) begin
      r_nxt   = t_red[WORD_BITS-1:0];
      b_nxt   = b_r << 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(WORD_BITS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (op_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = op_a;
      b_nxt    = op_b;
      r_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign op_done = done_r;
  assign op_r    = r_r;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Top level: right-to-left binary modular exponentiation sequencer.
//
//   channel   ports                                   handshake
//   input     start, busy, in_base                    start & !busy
//   result    out_valid, out_power_result             one-cycle strobe
//   config    cfg_we, cfg_index, cfg_wdata            write at cfg_we
//
// Every modular product runs through one shared multiplier. An item costs one
// product for the base reduction, then one decision step per exponent bit up to
// the highest set bit, a square for each bit below it and one more product for
// each set bit.
// Reset restores modulus 1 and exponent 65537 and leaves the block idle.
// The receiver cannot stall; each result is a single out_valid cycle.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation import modexp_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [FIELD_BITS-1:0]   in_base,
  output logic                    out_valid,
  output logic [FIELD_BITS-1:0]   out_power_result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_SQR  = 3'd4;

  logic [WORD_BITS-1:0] modulus_r;
  logic [WORD_BITS-1:0] exponent_r;

  logic [2:0]           state_r, state_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0] sq_r, sq_nxt;
  logic [WORD_BITS-1:0] exp_r, exp_nxt;
  logic                 mm_start_r, mm_start_nxt;
  logic [WORD_BITS-1:0] mm_a_r, mm_a_nxt;
  logic [WORD_BITS-1:0] mm_b_r, mm_b_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_res_r, out_res_nxt;

  logic [WORD_BITS:0]   n_eff;
  logic [WORD_BITS-1:0] one_mod;
  logic                 mm_done;
  logic [WORD_BITS-1:0] mm_r;

  // A zero modulus stands for 2^WORD_BITS, so arithmetic simply wraps.
  assign n_eff   = (modulus_r == '0) ? {1'b1, {WORD_BITS{1'b0}}} : {1'b0, modulus_r};
  assign one_mod = (n_eff == (WORD_BITS+1)'(1)) ? '0 : WORD_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= MOD_RESET[WORD_BITS-1:0];
      exponent_r <= EXP_RESET[WORD_BITS-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODULUS:  modulus_r  <= cfg_wdata[WORD_BITS-1:0];
        CFG_IDX_EXPONENT: exponent_r <= cfg_wdata[WORD_BITS-1:0];
      endcase
    end
  end

  modexp_mulmod #(
    .WORD_BITS(WORD_BITS)
  ) u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_start(mm_start_r),
    .op_a    (mm_a_r),
    .op_b    (mm_b_r),
    .op_n    (n_eff),
    .op_done (mm_done),
    .op_r    (mm_r)
  );

  // The base is reduced as base * 1 mod n on the shared multiplier.
  // After that, the squared term drives the multiplicand so it stays below n.
  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    exp_nxt       = exp_r;
    mm_start_nxt  = 1'b0;
    mm_a_nxt      = mm_a_r;
    mm_b_nxt      = mm_b_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          exp_nxt      = exponent_r;
          acc_nxt      = WORD_BITS'(1);
          mm_start_nxt = 1'b1;
          mm_a_nxt     = one_mod;
          mm_b_nxt     = in_base[WORD_BITS-1:0];
          state_nxt    = S_RED;
        end
      end
      S_RED: begin
        if (mm_done) begin
          sq_nxt    = mm_r;
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        if (exp_r == '0) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = acc_r;
          state_nxt     = S_IDLE;
        end else if (exp_r[0]) begin
          mm_start_nxt = 1'b1;
          mm_a_nxt     = sq_r;
          mm_b_nxt     = acc_r;
          state_nxt    = S_MUL;
        end else begin
          mm_start_nxt = 1'b1;
          mm_a_nxt     = sq_r;
          mm_b_nxt     = sq_r;
          state_nxt    = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_done) begin
          acc_nxt = mm_r;
          // No set bits remain, so the last square would go unused.
          if (exp_r[WORD_BITS-1:1] == '0) begin
            out_valid_nxt = 1'b1;
            out_res_nxt   = mm_r;
            state_nxt     = S_IDLE;
          end else begin
            mm_start_nxt = 1'b1;
            mm_a_nxt     = sq_r;
            mm_b_nxt     = sq_r;
            state_nxt    = S_SQR;
          end
        end
      end
      S_SQR: begin
        if (mm_done) begin
          sq_nxt    = mm_r;
          exp_nxt   = exp_r >> 1;
          state_nxt = S_STEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mm_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mm_start_r  <= mm_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    sq_r      <= sq_nxt;
    exp_r     <= exp_nxt;
    mm_a_r    <= mm_a_nxt;
    mm_b_r    <= mm_b_nxt;
    out_res_r <= out_res_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = FIELD_BITS'(out_res_r);

  `MX_ASSERT_SAME(a_out_idle, clk, rst_n, out_valid_r, state_r == S_IDLE,
    "result strobe while the sequencer is not idle")
  `MX_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy && !out_valid_r,
    "accepted transfer did not make the block busy")
  `MX_ASSERT_SAME(a_done_wait, clk, rst_n, mm_done,
    state_r == S_RED || state_r == S_MUL || state_r == S_SQR,
    "multiplier finished while the sequencer was not waiting")
  `MX_ASSERT_SAME(a_acc_range, clk, rst_n, state_r == S_STEP,
    acc_r == WORD_BITS'(1) || (WORD_BITS+1)'(acc_r) < n_eff,
    "accumulator left the residue range")

endmodule

// ===== dv/modexp_checker.sv =====
// Checker for the modular exponentiation block: tracks the registers, predicts each power, compares.
module modexp_checker import modexp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    busy,
  input  logic [FIELD_BITS-1:0]   in_base,
  input  logic                    out_valid,
  input  logic [FIELD_BITS-1:0]   out_power_result,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [FIELD_BITS-1:0]   cfg_wdata,
  input  logic                    end_check,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [FIELD_BITS-1:0] base;
    logic [FIELD_BITS-1:0] power;
  } power_entry_t;

  logic [FIELD_BITS-1:0] modulus_q;
  logic [FIELD_BITS-1:0] exponent_q;
  power_entry_t          expected_powers[$];
  int                    errors;
  logic                  end_done;

  // A modulus of zero stands for 2^32, so the reduction is a plain wrap.
  function automatic logic [63:0] mod_reduce(logic [63:0] x, logic [FIELD_BITS-1:0] n);
    if (n == '0) return {32'd0, x[31:0]};
    return x % {32'd0, n};
  endfunction

  function automatic logic [FIELD_BITS-1:0] power_mod(logic [FIELD_BITS-1:0] base,
                                                      logic [FIELD_BITS-1:0] n,
                                                      logic [FIELD_BITS-1:0] e);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = mod_reduce({32'd0, base}, n);
    for (int k = 0; k < FIELD_BITS; k++) begin
      if (e[k]) acc = mod_reduce(acc * sq, n);
      sq = mod_reduce(sq * sq, n);
    end
    return acc[FIELD_BITS-1:0];
  endfunction

  initial begin
    errors   = 0;
    end_done = 1'b0;
  end

  always @(posedge clk) begin
    power_entry_t entry;
    if (!rst_n) begin
      modulus_q  = MOD_RESET;
      exponent_q = EXP_RESET;
    end else begin
      // The prediction is pushed first so that a result in the cycle of its
      // own input transfer still finds it.
      if (start && !busy) begin
        entry.base  = in_base;
        entry.power = power_mod(in_base, modulus_q, exponent_q);
        expected_powers.push_back(entry);
      end
      if (out_valid) begin
        if (expected_powers.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h, expected none", $time, out_power_result);
        end else begin
          entry = expected_powers.pop_front();
          if (out_power_result !== entry.power) begin
            errors++;
            $display("%0t: power_result for base %h: expected %h, actual %h",
                     $time, entry.base, entry.power, out_power_result);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_MODULUS:  modulus_q  = cfg_wdata;
          CFG_IDX_EXPONENT: exponent_q = cfg_wdata;
          default: ;
        endcase
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (expected_powers.size() != 0) begin
          errors += expected_powers.size();
          $display("%0t: %0d expected results never arrived, first expected %h",
                   $time, expected_powers.size(), expected_powers[0].power);
        end
      end
    end
    fail_count <= errors;
    pending    <= expected_powers.size();
  end

endmodule

// ===== dv/tb_modular_exponentiation.sv =====
// Testbench top for the modular exponentiation block: stimulus, timeout and verdict.
module tb_modular_exponentiation;
  import modexp_pkg::*;

  localparam int MAX_CYCLES      = 3_000_000;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 19;
  localparam int DRAIN_CYCLES    = 2300;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic [FIELD_BITS-1:0]   in_base;
  logic                    out_valid;
  logic [FIELD_BITS-1:0]   out_power_result;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [FIELD_BITS-1:0]   cfg_wdata;
  logic                    end_check;
  int                      fail_count;
  int                      pending;
  int                      cycle_count = 0;
  logic [FIELD_BITS-1:0]   cur_modulus;

  modular_exponentiation DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base          (in_base),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  modexp_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base          (in_base),
    .out_valid        (out_valid),
    .out_power_result (out_power_result),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .end_check        (end_check),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("[modular_exponentiation] ERROR");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [FIELD_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_IDX_MODULUS) cur_modulus = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_power_config(input logic [FIELD_BITS-1:0] m, input logic [FIELD_BITS-1:0] e);
    write_reg(CFG_IDX_MODULUS, m);
    write_reg(CFG_IDX_EXPONENT, e);
  endtask

  // Holds the sender off until every predicted result has been seen.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
  endtask

  // Start stays high from one transfer into the next when the gap is zero.
  task automatic send_base(input logic [FIELD_BITS-1:0] b, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_base <= b;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_modulus();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return $urandom_range(2, 255);
      4:       return 32'hFFFF_FFFB;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_exponent();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return EXP_RESET;
      3:       return $urandom_range(1, 16);
      4:       return $urandom_range(0, 255);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FIELD_BITS-1:0] pick_base(logic [FIELD_BITS-1:0] m);
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 3);
      1:       return m - 1;
      2:       return m;
      3:       return m + $urandom_range(1, 1000);
      4:       return (m == '0) ? $urandom() : $urandom() % m;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic burst;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_base     = '0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IDX_MODULUS;
    cfg_wdata   = '0;
    end_check   = 1'b0;
    cur_modulus = MOD_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: modulus one with exponent 65537 gives zero for any base.
    send_base('0, $urandom_range(0, 11));
    send_base('1, $urandom_range(0, 11));
    send_base(32'd2, 0);

    drain();
    set_power_config('1, '1);
    send_base(32'hFFFF_FFFE, 0);
    send_base('1, $urandom_range(0, 11));
    send_base(32'h8000_0000, 0);

    // A zero modulus wraps all arithmetic at 32 bits.
    drain();
    set_power_config('0, '1);
    send_base(32'd3, $urandom_range(0, 11));
    send_base('1, 0);

    // A zero exponent yields one even with a modulus of one.
    drain();
    set_power_config(32'd1, '0);
    send_base(32'd5, $urandom_range(0, 11));
    drain();
    write_reg(CFG_IDX_EXPONENT, 32'd7);
    send_base(32'd5, 0);

    drain();
    set_power_config(32'hFFFF_FFFB, '0);
    send_base('0, 0);
    send_base('1, $urandom_range(0, 11));

    drain();
    set_power_config(32'd1000003, 32'd1);
    send_base('0, 0);
    send_base(32'd1000002, 0);
    send_base(32'd1000003, $urandom_range(0, 11));
    send_base('1, 0);

    drain();
    set_power_config('0, 32'd2);
    send_base('1, 0);
    send_base(32'h0001_0000, $urandom_range(0, 11));

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_IDX_MODULUS, pick_modulus());
        1:       write_reg(CFG_IDX_EXPONENT, pick_exponent());
        default: set_power_config(pick_modulus(), pick_exponent());
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 24) == 0) drain();
        send_base(pick_base(cur_modulus), burst ? 0 : $urandom_range(0, 11));
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    end_check <= 1'b1;
    repeat (2) @(negedge clk);
    if (fail_count == 0) begin
      $display("[modular_exponentiation] OK");
    end else begin
      $display("[modular_exponentiation] ERROR");
    end
    $finish;
  end

endmodule

// ===== modular_exponentiation.f =====
+incdir+hw/rtl
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_mulmod.sv
hw/rtl/modular_exponentiation.sv
dv/modexp_checker.sv
dv/tb_modular_exponentiation.sv
